@@ src/bounded_double_ended_queue_top_defines.svh @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top_defines
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define BDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define BDQ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ src/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, types and action codes of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [CAP_W-1:0]             cap_t;
	typedef logic [1:0]                   action_t;

	localparam action_t ACT_PUSH_BACK  = 2'd0;
	localparam action_t ACT_PUSH_FRONT = 2'd1;
	localparam action_t ACT_POP_FRONT  = 2'd2;
	localparam action_t ACT_POP_BACK   = 2'd3;

	localparam logic REG_CAPACITY = 1'b0;

	// Controller to datapath commands.
	typedef struct packed {
		logic latch;
		logic exec;
		logic respond;
	} bdq_cmd_t;

endpackage

@@ src/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a transaction, run the execute state, then the response state.
// ----------------------------------------------------------------------------
`include "bounded_double_ended_queue_top_defines.svh"

module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output bdq_pkg::bdq_cmd_t cmd
);
	import bdq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy        = (state_q == S_EXEC);
	assign accept      = start && !busy;
	assign cmd.latch   = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.respond = (state_q == S_RESP);

	always_comb begin
		unique case (state_q)
			S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
			S_EXEC:  state_d = S_RESP;
			S_RESP:  state_d = accept ? S_EXEC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`BDQ_ASSERT(a_accept_busy, accept |=> busy, "accepted transaction did not enter execute")
	`BDQ_ASSERT(a_resp_after_exec, (state_q == S_RESP) |-> ($past(state_q) == S_EXEC),
		"response without an execute cycle")
	`BDQ_ASSERT(a_single_resp, cmd.respond |=> !cmd.respond, "response held over two cycles")

endmodule

@@ src/bdq_dpath.sv @@
// ----------------------------------------------------------------------------
// bdq_dpath
// Ring store, head index, entry count and result registers of the deque.
// ----------------------------------------------------------------------------
`include "bounded_double_ended_queue_top_defines.svh"

module bdq_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_pkg::bdq_cmd_t cmd,
	input  bdq_pkg::action_t  action,
	input  bdq_pkg::value_t   push_value,
	input  bdq_pkg::cap_t     capacity,
	output bdq_pkg::value_t   popped_value,
	output logic              refused,
	output bdq_pkg::cnt_t     count_after,
	output logic              is_empty,
	output logic              is_full
);
	import bdq_pkg::*;

	value_t  mem [DEPTH];

	action_t act_q;
	value_t  val_q;
	idx_t    head_q;
	cnt_t    count_q;
	value_t  rd_data_q;
	logic    refused_q;
	logic    pop_ok_q;

	cnt_t    eff_cap;
	logic    is_push;
	logic    at_cap;
	logic    none;
	logic    push_ok;
	logic    pop_ok;
	idx_t    head_m1;
	idx_t    tail;
	idx_t    back;
	idx_t    wr_addr;
	idx_t    rd_addr;

	// Effective capacity is the register clipped to the ring depth.
	assign eff_cap = (cnt_t'(capacity) > cnt_t'(DEPTH)) ? cnt_t'(DEPTH) : cnt_t'(capacity);
	assign is_push = !act_q[1];
	assign at_cap  = (count_q >= eff_cap);
	assign none    = (count_q == '0);
	assign push_ok = is_push && !at_cap;
	assign pop_ok  = !is_push && !none;
	assign head_m1 = head_q - idx_t'(1);
	assign tail    = head_q + count_q[IDX_W-1:0];
	assign back    = tail - idx_t'(1);
	assign wr_addr = (act_q == ACT_PUSH_FRONT) ? head_m1 : tail;
	assign rd_addr = (act_q == ACT_POP_FRONT) ? head_q : back;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= action;
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.exec) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			refused_q <= 1'b0;
			pop_ok_q  <= 1'b0;
		end else if (cmd.exec) begin
			refused_q <= is_push ? at_cap : none;
			pop_ok_q  <= pop_ok;
			if (push_ok) begin
				count_q <= count_q + cnt_t'(1);
				if (act_q == ACT_PUSH_FRONT) begin
					head_q <= head_m1;
				end
			end else if (pop_ok) begin
				count_q <= count_q - cnt_t'(1);
				if (act_q == ACT_POP_FRONT) begin
					head_q <= head_q + idx_t'(1);
				end
			end
		end
	end

	// Result fields are valid while the controller drives respond.
	always_comb begin
		if (pop_ok_q) begin
			popped_value = rd_data_q;
		end else if (refused_q && act_q[1]) begin
			popped_value = '1;
		end else begin
			popped_value = '0;
		end
	end

	assign refused     = refused_q;
	assign count_after = count_q;
	assign is_empty    = none;
	assign is_full     = at_cap;

	`BDQ_NEVER(a_count_bound, count_q > cnt_t'(DEPTH), "entry count beyond ring depth")
	`BDQ_ASSERT(a_push_grows, (cmd.exec && push_ok) |=> (count_q == $past(count_q) + cnt_t'(1)),
		"accepted push did not grow the count")
	`BDQ_ASSERT(a_refuse_hold, (cmd.exec && !push_ok && !pop_ok) |=>
		($stable(count_q) && $stable(head_q)), "refused action moved the queue")

endmodule

@@ src/bounded_double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// After the accepting edge the sequencer runs an execute state, then a respond
// state; done is high and the result is taken in the respond state.
// Start is taken again during the response state; busy refuses it only in the
// execute state, in which the ring store is accessed.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) empties the queue and clears capacity to 0.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  bdq_pkg::action_t               action,
	input  bdq_pkg::value_t                push_value,
	// result channel
	output logic                           done,
	output bdq_pkg::value_t                popped_value,
	output logic                           refused,
	output bdq_pkg::cnt_t                  count_after,
	output logic                           is_empty,
	output logic                           is_full,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdq_pkg::ADDR_W-1:0]     paddr,
	input  logic [bdq_pkg::DATA_W-1:0]     pwdata,
	output logic [bdq_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import bdq_pkg::*;

	bdq_cmd_t cmd;
	cap_t     capacity_q;
	logic     cfg_wr;

	// Register decode ignores the byte offset; bit 2 selects the word.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Capacity register: the user must write it only between transactions; the block does not enforce this, so no guard.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Read back capacity; the unused word reads as zero.
	always_comb begin
		if (paddr[2] == REG_CAPACITY) begin
			prdata = {{(DATA_W-CAP_W){1'b0}}, capacity_q};
		end else begin
			prdata = '0;
		end
	end

	// Sequencer: accept, execute, respond.
	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Ring store and pointers; result fields hold during the respond cycle.
	bdq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.push_value   (push_value),
		.capacity     (capacity_q),
		.popped_value (popped_value),
		.refused      (refused),
		.count_after  (count_after),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// Strobe the result for the single respond cycle.
	assign done = cmd.respond;

endmodule

@@ sim/bounded_double_ended_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top_tb
// Self-checking bench for the bounded deque. A clocked driver issues push and
// pop commands from a pending list, a bit-true predictor of the ring works out
// each result as the command is taken, and a clocked monitor compares every
// result strobe against the oldest prediction. Capacity is reprogrammed over
// the APB port between phases while the deque is idle.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top_tb;
	import bdq_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;	// margin after the last result; leave room
	localparam int GAP_PCT       = 7;
	localparam int PHASE_ITEMS   = 85;

	typedef struct packed {
		action_t act;
		value_t  val;
	} deque_cmd_t;

	typedef struct packed {
		value_t popped;
		logic   refused;
		cnt_t   cnt;
		logic   empty;
		logic   full;
	} deque_result_t;

	// Stimulus side: every input starts at a known value.
	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	action_t             action     = ACT_PUSH_BACK;
	value_t              push_value = '0;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [ADDR_W-1:0]   paddr      = '0;
	logic [DATA_W-1:0]   pwdata     = '0;

	logic                busy;
	logic                done;
	value_t              popped_value;
	logic                refused;
	cnt_t                count_after;
	logic                is_empty;
	logic                is_full;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Predicted deque contents, mirrored from what the block has accepted.
	value_t              ring_store [DEPTH];
	idx_t                ring_head     = '0;
	int unsigned         ring_count    = 0;
	int unsigned         capacity_cfg  = 0;

	deque_cmd_t          pending_cmds [$];
	deque_result_t       expected_results [$];
	int unsigned         mismatch_count = 0;
	int unsigned         cycle_count    = 0;
	bit                  gaps_on        = 1'b1;

	bounded_double_ended_queue_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.push_value   (push_value),
		.done         (done),
		.popped_value (popped_value),
		.refused      (refused),
		.count_after  (count_after),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bounded_double_ended_queue_top regression: fail");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Advance the mirrored ring by one command and return the result it must
	// produce. Capacities above the ring depth clamp to the depth; a capacity
	// lowered below the fill keeps the entries and refuses further pushes.
	function automatic deque_result_t apply_action(input action_t act, input value_t val);
		deque_result_t r;
		int unsigned   limit;
		limit = (capacity_cfg > DEPTH) ? DEPTH : capacity_cfg;
		r = '0;
		case (act) inside
			ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (ring_count >= limit)
					r.refused = 1'b1;
				else if (act == ACT_PUSH_BACK) begin
					ring_store[idx_t'(ring_head + ring_count)] = val;
					ring_count++;
				end else begin
					ring_head = ring_head - 1'b1;
					ring_store[ring_head] = val;
					ring_count++;
				end
			end
			default: begin
				if (ring_count == 0) begin
					// Empty pop: refuse and return all ones.
					r.refused = 1'b1;
					r.popped  = '1;
				end else if (act == ACT_POP_FRONT) begin
					r.popped  = ring_store[ring_head];
					ring_head = ring_head + 1'b1;
					ring_count--;
				end else begin
					r.popped = ring_store[idx_t'(ring_head + ring_count - 1)];
					ring_count--;
				end
			end
		endcase
		r.cnt   = cnt_t'(ring_count);
		r.empty = (ring_count == 0);
		r.full  = (ring_count >= limit);
		return r;
	endfunction

	// Command driver: a transaction is accepted at an edge with start high and
	// busy low. Predict at that edge, then present the next pending command
	// or drop start for a random gap. Start is written once per edge so a
	// back-to-back command never sees a low-then-high pair in one step.
	always @(posedge clk) begin : cmd_driver
		deque_cmd_t nxt;
		logic       taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken)
				expected_results.push_back(apply_action(action, push_value));
			if (!start || taken) begin
				if (pending_cmds.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
					nxt = pending_cmds.pop_front();
					start      <= 1'b1;
					action     <= nxt.act;
					push_value <= nxt.val;
				end else begin
					// Idle: scramble the payload so it cannot leak into a result.
					start      <= 1'b0;
					action     <= action_t'($urandom_range(3));
					push_value <= value_t'($urandom);
				end
			end
		end
	end

	// Result monitor: each done strobe is one transaction and is matched
	// against the oldest prediction, field by field.
	always @(posedge clk) begin : result_monitor
		deque_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0)
				flag_mismatch("result strobe with no command outstanding");
			else begin
				want = expected_results.pop_front();
				if (popped_value !== want.popped)
					flag_mismatch($sformatf("popped_value %0d, expected %0d",
						popped_value, want.popped));
				if (refused !== want.refused)
					flag_mismatch($sformatf("refused %b, expected %b", refused, want.refused));
				if (count_after !== want.cnt)
					flag_mismatch($sformatf("count_after %0d, expected %0d",
						count_after, want.cnt));
				if (is_empty !== want.empty)
					flag_mismatch($sformatf("is_empty %b, expected %b", is_empty, want.empty));
				if (is_full !== want.full)
					flag_mismatch($sformatf("is_full %b, expected %b", is_full, want.full));
			end
		end
	end

	task automatic queue_cmd(input action_t act, input value_t val);
		deque_cmd_t c;
		c.act = act;
		c.val = val;
		pending_cmds.push_back(c);
	endtask

	// Favor the extremes of the value range over plain random words.
	function automatic value_t pick_value();
		case ($urandom_range(7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '1;
			3:       return '0;
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic fill_random(input int n, input int push_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < push_pct)
				queue_cmd($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
			else
				queue_cmd($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_value());
		end
	endtask

	// Hold until no command is pending or in flight, then let the pipeline
	// drain. Check on the falling edge so the driver's updates have landed.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the capacity register: setup cycle, then access cycle. The
	// register takes the value at the edge that ends the access cycle. Upper
	// data bits carry noise the register must ignore.
	task automatic program_capacity(input int unsigned cap);
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= ($urandom & 32'hFFFF_FFE0) | (cap & 32'h1F);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		capacity_cfg = cap & 32'h1F;
	endtask

	initial begin : sequencer
		int unsigned cap_plan  [10];
		int          push_plan [10];

		cap_plan  = '{16, 31, 17, 1, 0, 5, 16, 2, 9, 31};
		push_plan = '{80, 40, 75, 50, 50, 60, 70, 45, 65, 25};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Zero capacity out of reset: every command is refused, queue reads
		// both empty and full.
		queue_cmd(ACT_PUSH_BACK,  32'h7FFF_FFFF);
		queue_cmd(ACT_PUSH_FRONT, 32'h8000_0000);
		queue_cmd(ACT_POP_FRONT,  '0);
		queue_cmd(ACT_POP_BACK,   '1);

		// Small capacity: fill from both ends, overflow, drain from both
		// ends, then pop the empty queue from the back and refill to full.
		program_capacity(3);
		queue_cmd(ACT_PUSH_BACK,  32'h7FFF_FFFF);
		queue_cmd(ACT_PUSH_FRONT, 32'h8000_0000);
		queue_cmd(ACT_PUSH_BACK,  '1);
		queue_cmd(ACT_PUSH_FRONT, '0);
		queue_cmd(ACT_POP_BACK,   '0);
		queue_cmd(ACT_POP_FRONT,  '0);
		queue_cmd(ACT_POP_FRONT,  '0);
		queue_cmd(ACT_POP_BACK,   '0);
		queue_cmd(ACT_PUSH_BACK,  32'h5A5A_5A5A);
		queue_cmd(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
		queue_cmd(ACT_PUSH_BACK,  '0);

		// Capacity lowered below the fill: entries stay, pushes are refused
		// until the queue drains under the new limit.
		program_capacity(1);
		queue_cmd(ACT_PUSH_BACK,  32'h1234_5678);
		queue_cmd(ACT_PUSH_FRONT, 32'h1234_5678);
		queue_cmd(ACT_POP_BACK,   '0);
		queue_cmd(ACT_POP_FRONT,  '0);
		queue_cmd(ACT_POP_FRONT,  '0);
		queue_cmd(ACT_PUSH_BACK,  32'h0000_0001);
		queue_cmd(ACT_POP_BACK,   '0);

		// Random phases: fill-heavy, balanced and drain-heavy mixes across
		// capacities including the clamp above depth, zero and one. Drop
		// idling for two phases in a row to get a long back-to-back stretch.
		for (int p = 0; p < 10; p++) begin
			program_capacity(cap_plan[p]);
			gaps_on = !(p == 6 || p == 7);
			fill_random(PHASE_ITEMS, push_plan[p]);
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("bounded_double_ended_queue_top regression: pass");
		else
			$display("bounded_double_ended_queue_top regression: fail");
		$finish;
	end

endmodule
